// File: hw/rtl/ray_side_distance_init_macros.svh
// ----------------------------------------------------------------------------
// ray_side_distance_init_macros.svh
// Assertion macros used by the ray side-distance RTL.
// ----------------------------------------------------------------------------
`ifndef RAY_SIDE_DISTANCE_INIT_MACROS_SVH
`define RAY_SIDE_DISTANCE_INIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define RSDI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsdi: same-cycle check failed");
// Next-cycle implication.
`define RSDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsdi: next-cycle check failed");
`else
`define RSDI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RSDI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/rsdi_pkg.sv
// ----------------------------------------------------------------------------
// rsdi_pkg
// Widths, constants and lane types of the ray side-distance pipeline.
// ----------------------------------------------------------------------------
package rsdi_pkg;
	localparam int CELL_SIZE_DEF  = 64;
	localparam int ANGLE_BITS_DEF = 16;

	localparam int FOV_W    = 16;
	localparam int ANG_IN_W = 16;
	localparam int POS_W    = 24;
	localparam int DIST_W   = 24;
	localparam int CLS_W    = 3;
	localparam int OFS_W    = 21;
	localparam int TRIG_W   = 32;
	localparam int QUO_W    = 24;
	localparam int U_W      = 17;

	localparam int TERM_CELLS = 5;
	localparam int DIV_CELLS  = QUO_W;
	localparam int RECIP_SH   = 35;

	localparam logic [FOV_W-1:0]  FOV_RESET   = 16'd10923;
	localparam logic [31:0]       HALF_PI_Q30 = 32'd1686629713;
	localparam logic [DIST_W-1:0] ALL_ONES24  = '1;
	localparam logic [U_W-1:0]    ONE_QUARTER_U = 17'h10000;

	localparam logic REG_FOV = 1'b0;

	typedef enum logic [CLS_W-1:0] {
		CLS_Q1    = 3'd0,
		CLS_Q2    = 3'd1,
		CLS_Q3    = 3'd2,
		CLS_Q4    = 3'd3,
		CLS_UP    = 3'd4,
		CLS_LEFT  = 3'd5,
		CLS_DOWN  = 3'd6,
		CLS_RIGHT = 3'd7
	} ray_class_t;

	typedef struct packed {
		logic [TRIG_W-1:0] term;
		logic [TRIG_W-1:0] sum;
		logic [TRIG_W-1:0] th2;
	} sin_lane_t;

	typedef struct packed {
		logic              sat;
		logic [TRIG_W-1:0] trig;
		logic [TRIG_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_lane_t;

	typedef struct packed {
		ray_class_t       cls;
		logic             axis;
		logic [DIST_W-1:0] ax_dx;
		logic [DIST_W-1:0] ax_dy;
		logic [OFS_W-1:0]  offx;
		logic [OFS_W-1:0]  offy;
	} side_t;
endpackage

// File: hw/rtl/rsdi_term_cell.sv
// ----------------------------------------------------------------------------
// rsdi_term_cell
// One Taylor term of the sine series: next term and running sum, 3 stages.
// ----------------------------------------------------------------------------
module rsdi_term_cell import rsdi_pkg::*; #(
	parameter int K = 1
) (
	input  logic      clk,
	input  logic      en,
	input  sin_lane_t lane_i,
	output sin_lane_t lane_o
);
	localparam int DIVISOR = (2 * K) * (2 * K + 1);
	localparam logic [32:0] RECIP = 33'((64'd1 << RECIP_SH) / DIVISOR);
	localparam logic [7:0]  DIV_C = 8'(DIVISOR);

	logic [63:0]       prod_a;
	logic [TRIG_W-1:0] x_s1, sum_s1, th2_s1;
	logic [64:0]       prod_b;
	logic [TRIG_W-1:0] x_s2, q0_s2, sum_s2, th2_s2;
	logic [39:0]       qd;
	logic [TRIG_W-1:0] rem, q;
	sin_lane_t         nxt;

	assign prod_a = 64'(lane_i.term) * 64'(lane_i.th2);
	assign prod_b = 65'(x_s1) * 65'(RECIP);

	// reciprocal estimate is exact or one short: correct with one compare
	always_comb begin
		qd  = 40'(q0_s2) * 40'(DIV_C);
		rem = x_s2 - qd[TRIG_W-1:0];
		q   = (rem >= TRIG_W'(DIVISOR)) ? q0_s2 + 1'b1 : q0_s2;
		nxt.term = q;
		nxt.th2  = th2_s2;
		if (K % 2 == 1) begin
			nxt.sum = (sum_s2 < q) ? '0 : sum_s2 - q;
		end else begin
			nxt.sum = sum_s2 + q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= prod_a[61:30];
			sum_s1 <= lane_i.sum;
			th2_s1 <= lane_i.th2;
			x_s2   <= x_s1;
			q0_s2  <= TRIG_W'(prod_b >> RECIP_SH);
			sum_s2 <= sum_s1;
			th2_s2 <= th2_s1;
			lane_o <= nxt;
		end
	end
endmodule

// File: hw/rtl/rsdi_div_cell.sv
// ----------------------------------------------------------------------------
// rsdi_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module rsdi_div_cell import rsdi_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_lane_t lane_i,
	output div_lane_t lane_o
);
	logic [TRIG_W-1:0] t;
	div_lane_t         nxt;

	// remainder stays below the divisor, so the shift never loses a bit
	always_comb begin
		t = {lane_i.rem[TRIG_W-2:0], 1'b0};
		nxt = lane_i;
		if (t >= lane_i.trig) begin
			nxt.rem = t - lane_i.trig;
			nxt.quo = {lane_i.quo[QUO_W-2:0], 1'b1};
		end else begin
			nxt.rem = t;
			nxt.quo = {lane_i.quo[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o <= nxt;
		end
	end
endmodule

// File: hw/rtl/ray_side_distance_init.sv
// ----------------------------------------------------------------------------
// ray_side_distance_init
// Grid DDA set-up for one ray: angle, class and distances to the first
// vertical and horizontal cell boundaries.
//
// Input channel (in_valid/in_ready) carries centre angle, column step and
// player position; output channel (out_valid/out_ready) returns dist_x,
// dist_y and ray_class, one result per input transfer, in order.
// Throughput is one ray per cycle while the receiver does not stall. From
// input transfer to out_valid a ray passes 3 front stages, 3 per sine term
// cell (5 cells, cos and sin side by side), one divide set-up stage, one
// stage per quotient bit (24 restoring cells) and the output register.
// field_of_view sits behind the APB port at address 0 and resets to 10923.
// Reset empties the pipeline and drops any result not yet taken.
// When the receiver stalls the whole chain holds; in_ready follows
// !out_valid || out_ready, so a new transfer still enters while the output
// register drains.
// ----------------------------------------------------------------------------
`include "ray_side_distance_init_macros.svh"

module ray_side_distance_init import rsdi_pkg::*; #(
	parameter int CELL_SIZE  = CELL_SIZE_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// ray input
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ANG_IN_W-1:0] center_angle,
	input  logic [ANG_IN_W-1:0] angle_step,
	input  logic [POS_W-1:0]    player_x,
	input  logic [POS_W-1:0]    player_y,
	// result output
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIST_W-1:0]   dist_x,
	output logic [DIST_W-1:0]   dist_y,
	output logic [CLS_W-1:0]    ray_class
);
	localparam int AB        = ANGLE_BITS;
	localparam int CELLQ     = CELL_SIZE * 256;
	localparam int SHL       = (AB <= 18) ? 18 - AB : 0;
	localparam int SHR       = (AB > 18) ? AB - 18 : 0;
	localparam int SIDE_DLY  = 3 * TERM_CELLS + 1 + DIV_CELLS;
	localparam int LAT_DATA  = 3 + SIDE_DLY;
	localparam logic [OFS_W-1:0] CELLQ_V = OFS_W'(CELLQ);
	localparam logic [18:0]      M_CELL  = 19'((64'd1 << 27) / CELLQ);
	localparam logic [AB-1:0]    A_QTR   = AB'(1) << (AB - 2);
	localparam logic [AB-1:0]    A_HALF  = AB'(2) << (AB - 2);
	localparam logic [AB-1:0]    A_3QTR  = AB'(3) << (AB - 2);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [FOV_W-1:0] fov_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FOV) ? 32'(fov_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q <= FOV_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FOV) begin
			fov_q <= pwdata[FOV_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Flow control: one enable for every stage; stall all when the
	// output register is full and not being taken.
	// ------------------------------------------------------------------
	logic                adv;
	logic [LAT_DATA-1:0] vld_q;
	logic                out_valid_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[LAT_DATA-2:0], in_valid};
			out_valid_q <= vld_q[LAT_DATA-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: ray angle, class, reduced angle, cell-offset estimate
	// ------------------------------------------------------------------
	logic [25:0]    a_full;
	logic [AB-1:0]  a, r;
	ray_class_t     cls;
	logic           axis;
	logic [U_W-1:0] u;
	logic [42:0]    pmx, pmy;

	always_comb begin
		a_full = 26'(center_angle) + 26'(fov_q >> 1) - 26'(angle_step);
		a      = a_full[AB-1:0];
		axis   = 1'b1;
		r      = '0;
		if (a == '0) begin
			cls = CLS_RIGHT;
		end else if (a == A_QTR) begin
			cls = CLS_UP;
		end else if (a == A_HALF) begin
			cls = CLS_LEFT;
		end else if (a == A_3QTR) begin
			cls = CLS_DOWN;
		end else begin
			axis = 1'b0;
			// reduce into the first quadrant; wrap-around does the rest
			case (a[AB-1:AB-2])
				2'd0:    begin cls = CLS_Q1; r = a;          end
				2'd1:    begin cls = CLS_Q2; r = A_HALF - a; end
				2'd2:    begin cls = CLS_Q3; r = a - A_HALF; end
				default: begin cls = CLS_Q4; r = '0 - a;     end
			endcase
		end
		u   = U_W'((32'(r) << SHL) >> SHR);
		pmx = 43'(player_x) * 43'(M_CELL);
		pmy = 43'(player_y) * 43'(M_CELL);
	end

	ray_class_t     cls_s1;
	logic           axis_s1;
	logic [U_W-1:0] u_s1, uc_s1;
	logic [POS_W-1:0] px_s1, py_s1;
	logic [16:0]    qx_s1, qy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= cls;
			axis_s1 <= axis;
			u_s1    <= u;
			uc_s1   <= ONE_QUARTER_U - u;
			px_s1   <= player_x;
			py_s1   <= player_y;
			qx_s1   <= 17'(pmx >> 27);
			qy_s1   <= 17'(pmy >> 27);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: angles in radians (Q30), exact offsets inside the cell
	// ------------------------------------------------------------------
	logic [48:0] ths_p, thc_p;
	logic [24:0] rx, ry;

	always_comb begin
		ths_p = 49'(u_s1) * 49'(HALF_PI_Q30);
		thc_p = 49'(uc_s1) * 49'(HALF_PI_Q30);
		rx    = 25'(px_s1) - 25'(qx_s1) * 25'(CELLQ);
		ry    = 25'(py_s1) - 25'(qy_s1) * 25'(CELLQ);
	end

	ray_class_t        cls_s2;
	logic              axis_s2;
	logic [TRIG_W-1:0] ths_s2, thc_s2;
	logic [OFS_W-1:0]  mx_s2, my_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2  <= cls_s1;
			axis_s2 <= axis_s1;
			ths_s2  <= TRIG_W'(ths_p >> 16);
			thc_s2  <= TRIG_W'(thc_p >> 16);
			// estimate is at most one cell short
			mx_s2   <= OFS_W'((rx >= 25'(CELLQ)) ? rx - 25'(CELLQ) : rx);
			my_s2   <= OFS_W'((ry >= 25'(CELLQ)) ? ry - 25'(CELLQ) : ry);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: theta squared, per-axis offsets, axis answers
	// ------------------------------------------------------------------
	logic [63:0] ths_sq, thc_sq;
	side_t       side;

	always_comb begin
		ths_sq     = 64'(ths_s2) * 64'(ths_s2);
		thc_sq     = 64'(thc_s2) * 64'(thc_s2);
		side.cls   = cls_s2;
		side.axis  = axis_s2;
		side.offx  = (cls_s2 == CLS_Q1 || cls_s2 == CLS_Q4) ? CELLQ_V - mx_s2 : mx_s2;
		side.offy  = (cls_s2 == CLS_Q3 || cls_s2 == CLS_Q4) ? CELLQ_V - my_s2 : my_s2;
		side.ax_dx = ALL_ONES24;
		side.ax_dy = ALL_ONES24;
		case (cls_s2)
			CLS_RIGHT: side.ax_dx = DIST_W'(CELLQ_V - mx_s2);
			CLS_LEFT:  side.ax_dx = DIST_W'(mx_s2);
			CLS_UP:    side.ax_dy = DIST_W'(my_s2);
			CLS_DOWN:  side.ax_dy = DIST_W'(CELLQ_V - my_s2);
			default:   ;
		endcase
	end

	sin_lane_t sin_s [TERM_CELLS+1];
	sin_lane_t cos_s [TERM_CELLS+1];
	side_t     side_q [SIDE_DLY+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_s[0].term <= ths_s2;
			sin_s[0].sum  <= ths_s2;
			sin_s[0].th2  <= ths_sq[61:30];
			cos_s[0].term <= thc_s2;
			cos_s[0].sum  <= thc_s2;
			cos_s[0].th2  <= thc_sq[61:30];
			side_q[0]     <= side;
		end
	end

	// hold class and offsets alongside the arithmetic chains
	for (genvar i = 0; i < SIDE_DLY; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_q[i+1] <= side_q[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sine series: one cell per term, cos as sine of the complement
	// ------------------------------------------------------------------
	for (genvar k = 0; k < TERM_CELLS; k++) begin : g_term
		rsdi_term_cell #(.K(k + 1)) u_sin (
			.clk    (clk),
			.en     (adv),
			.lane_i (sin_s[k]),
			.lane_o (sin_s[k+1])
		);
		rsdi_term_cell #(.K(k + 1)) u_cos (
			.clk    (clk),
			.en     (adv),
			.lane_i (cos_s[k]),
			.lane_o (cos_s[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Divide set-up: quotient overflows 24 bits exactly when
	// offset << 6 >= trig, which also covers a zero trig value
	// ------------------------------------------------------------------
	div_lane_t         dvx [DIV_CELLS+1];
	div_lane_t         dvy [DIV_CELLS+1];
	logic [TRIG_W-1:0] numx, numy;
	side_t             side_pre;

	always_comb begin
		side_pre = side_q[3 * TERM_CELLS];
		numx     = TRIG_W'(side_pre.offx) << 6;
		numy     = TRIG_W'(side_pre.offy) << 6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvx[0].sat  <= numx >= cos_s[TERM_CELLS].sum;
			dvx[0].trig <= cos_s[TERM_CELLS].sum;
			dvx[0].rem  <= numx;
			dvx[0].quo  <= '0;
			dvy[0].sat  <= numy >= sin_s[TERM_CELLS].sum;
			dvy[0].trig <= sin_s[TERM_CELLS].sum;
			dvy[0].rem  <= numy;
			dvy[0].quo  <= '0;
		end
	end

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		rsdi_div_cell u_dvx (
			.clk    (clk),
			.en     (adv),
			.lane_i (dvx[j]),
			.lane_o (dvx[j+1])
		);
		rsdi_div_cell u_dvy (
			.clk    (clk),
			.en     (adv),
			.lane_i (dvy[j]),
			.lane_o (dvy[j+1])
		);
	end

	// ------------------------------------------------------------------
	// Output register: pick axis answer, saturate or quotient
	// ------------------------------------------------------------------
	side_t side_out;

	assign side_out = side_q[SIDE_DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_class <= side_out.cls;
			if (side_out.axis) begin
				dist_x <= side_out.ax_dx;
				dist_y <= side_out.ax_dy;
			end else begin
				dist_x <= dvx[DIV_CELLS].sat ? ALL_ONES24 : dvx[DIV_CELLS].quo;
				dist_y <= dvy[DIV_CELLS].sat ? ALL_ONES24 : dvy[DIV_CELLS].quo;
			end
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`RSDI_ASSERT_SAME(a_vert_no_x, clk, arst_n, out_valid && (ray_class == CLS_UP || ray_class == CLS_DOWN), dist_x == ALL_ONES24)
	`RSDI_ASSERT_SAME(a_horz_no_y, clk, arst_n, out_valid && (ray_class == CLS_LEFT || ray_class == CLS_RIGHT), dist_y == ALL_ONES24)
	`RSDI_ASSERT_NEXT(a_last_to_out, clk, arst_n, adv && vld_q[LAT_DATA-1], out_valid)
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray side-distance block: a short table of
// directed rays, then random rays under several field-of-view settings,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import rsdi_pkg::*;

	localparam int  CELL_Q      = 64 * 256;
	localparam int  QUARTER     = 16384;
	localparam int  WATCH_LIMIT = 4000;
	localparam int  DRAIN_WAIT  = 60;
	localparam logic [2:0] FOV_ADDR = 3'(4 * REG_FOV);

	typedef struct packed {
		logic [15:0] center;
		logic [15:0] step;
		logic [23:0] px;
		logic [23:0] py;
	} ray_t;

	typedef struct packed {
		logic [23:0] dx;
		logic [23:0] dy;
		ray_class_t  cls;
	} sides_t;

	typedef struct packed {
		ray_t   ray;
		logic   typed;
		sides_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] center_angle = '0, angle_step = '0;
	logic [23:0] player_x = '0, player_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] dist_x, dist_y;
	logic [2:0]  ray_class;

	// bench-side copy of the register and of the row in flight
	logic [15:0] fov_model = FOV_RESET;
	logic        row_typed = 1'b0;
	sides_t      row_want = '0;

	sides_t      pending_sides[$];
	int          fail_count = 0;
	bit          idle_on = 1'b1;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	ray_side_distance_init dut (.*);

	always #2 clk = ~clk;

	// Taylor sine of a Q16 quarter-turn fraction, Q30 result
	function automatic longint unsigned sine_q30(longint unsigned u);
		longint unsigned theta, th2, term, sum;
		theta = (u * 64'd1686629713) >> 16;
		th2   = (theta * theta) >> 30;
		term  = theta;
		sum   = theta;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = (sum < term) ? 0 : sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic logic [23:0] side_length(longint unsigned ofs, longint unsigned trig);
		longint unsigned q;
		if (trig == 0)
			return ALL_ONES24;
		q = (ofs << 30) / trig;
		return (q > 64'hFFFFFF) ? ALL_ONES24 : q[23:0];
	endfunction

	function automatic sides_t predict_sides(ray_t r, logic [15:0] fov);
		logic [15:0]     ang;
		longint unsigned mx, my, red, u, ofx, ofy;
		sides_t          s;
		ang = r.center + (fov >> 1) - r.step;
		mx  = r.px % CELL_Q;
		my  = r.py % CELL_Q;
		if (ang == 0) begin
			s = '{24'(CELL_Q - mx), ALL_ONES24, CLS_RIGHT};
		end else if (ang == QUARTER) begin
			s = '{ALL_ONES24, 24'(my), CLS_UP};
		end else if (ang == 2 * QUARTER) begin
			s = '{24'(mx), ALL_ONES24, CLS_LEFT};
		end else if (ang == 3 * QUARTER) begin
			s = '{ALL_ONES24, 24'(CELL_Q - my), CLS_DOWN};
		end else begin
			if (ang < QUARTER) begin
				s.cls = CLS_Q1; red = ang; ofx = CELL_Q - mx; ofy = my;
			end else if (ang < 2 * QUARTER) begin
				s.cls = CLS_Q2; red = 2 * QUARTER - ang; ofx = mx; ofy = my;
			end else if (ang < 3 * QUARTER) begin
				s.cls = CLS_Q3; red = ang - 2 * QUARTER; ofx = mx; ofy = CELL_Q - my;
			end else begin
				s.cls = CLS_Q4; red = 4 * QUARTER - ang; ofx = CELL_Q - mx;
				ofy = CELL_Q - my;
			end
			u = red << 2;
			s.dx = side_length(ofx, sine_q30(65536 - u));
			s.dy = side_length(ofy, sine_q30(u));
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Monitor: predict on input transfers, check on output transfers
	always @(posedge clk) begin
		sides_t w;
		if (in_valid && in_ready) begin
			if (row_typed)
				pending_sides.push_back(row_want);
			else
				pending_sides.push_back(predict_sides(
					'{center_angle, angle_step, player_x, player_y}, fov_model));
		end
		if (out_valid && out_ready) begin
			if (pending_sides.size() == 0) begin
				$display("unexpected result at %0t", $time);
				fail_count++;
			end else begin
				w = pending_sides.pop_front();
				if (dist_x !== w.dx) report_mismatch("dist_x", dist_x, w.dx);
				if (dist_y !== w.dy) report_mismatch("dist_y", dist_y, w.dy);
				if (ray_class !== w.cls)
					report_mismatch("ray_class", 24'(ray_class), 24'(w.cls));
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_fov(logic [15:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= FOV_ADDR; pwdata <= {16'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		fov_model = v;
	endtask

	// Offer one ray, hold it until the transfer, then maybe leave a gap
	task automatic send_ray(ray_t r, logic typed, sides_t want);
		in_valid <= 1'b1;
		center_angle <= r.center; angle_step <= r.step;
		player_x <= r.px; player_y <= r.py;
		row_typed <= typed; row_want <= want;
		do @(posedge clk); while (!in_ready);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Random ray, biased towards axis angles and cell boundaries
	function automatic ray_t random_ray(logic [15:0] fov);
		ray_t r;
		int   pick;
		r.center = 16'($urandom);
		r.step   = 16'($urandom);
		r.px     = 24'($urandom);
		r.py     = 24'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 2)
			r.step = r.center + (fov >> 1) - 16'($urandom_range(0, 3) * QUARTER);
		else if (pick == 2)
			r.step = r.center + (fov >> 1) - 16'($urandom_range(0, 3) * QUARTER)
				+ 16'($urandom_range(0, 6)) - 16'd3;
		if ($urandom_range(0, 7) == 0) r.px[13:0] = $urandom_range(0, 1) ? '0 : '1;
		if ($urandom_range(0, 7) == 0) r.py[13:0] = $urandom_range(0, 1) ? '0 : '1;
		return r;
	endfunction

	task automatic drain_results();
		int guard;
		guard = 0;
		while (pending_sides.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Directed rays at the reset field of view (half of it is 5461)
	dir_row_t dir_rows[18] = '{
		'{'{16'd0,     16'd5461, 24'h001234, 24'h00ABCD}, 1'b1,
			'{24'h002DCC, 24'hFFFFFF, CLS_RIGHT}},
		'{'{16'd16384, 16'd5461, 24'h000000, 24'hFFFFFF}, 1'b1,
			'{24'hFFFFFF, 24'h003FFF, CLS_UP}},
		'{'{16'd32768, 16'd5461, 24'hFFFFFF, 24'h123456}, 1'b1,
			'{24'h003FFF, 24'hFFFFFF, CLS_LEFT}},
		'{'{16'd49152, 16'd5461, 24'h777777, 24'h000000}, 1'b1,
			'{24'hFFFFFF, 24'h004000, CLS_DOWN}},
		'{'{16'hFFFF, 16'h0000, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
		'{'{16'h0000, 16'hFFFF, 24'h000000, 24'h000000}, 1'b0, '0},
		'{'{16'd0,     16'd5460, 24'h00A000, 24'h002000}, 1'b0, '0},
		'{'{16'd0,     16'd5462, 24'h00A000, 24'h002000}, 1'b0, '0},
		'{'{16'd16384, 16'd5462, 24'h003000, 24'h001000}, 1'b0, '0},
		'{'{16'd16384, 16'd5460, 24'h003000, 24'h001000}, 1'b0, '0},
		'{'{16'd32768, 16'd5462, 24'h008001, 24'h0FFFFF}, 1'b0, '0},
		'{'{16'd32768, 16'd5460, 24'h008001, 24'h0FFFFF}, 1'b0, '0},
		'{'{16'd49152, 16'd5462, 24'h5A5A5A, 24'hA5A5A5}, 1'b0, '0},
		'{'{16'd49152, 16'd5460, 24'h5A5A5A, 24'hA5A5A5}, 1'b0, '0},
		'{'{16'd8192,  16'd5461, 24'h004000, 24'h000000}, 1'b0, '0},
		'{'{16'd24576, 16'd5461, 24'h000000, 24'h123456}, 1'b0, '0},
		'{'{16'd40960, 16'd5461, 24'h00FFFF, 24'hFF0000}, 1'b0, '0},
		'{'{16'd57344, 16'd5461, 24'hABCDEF, 24'hFEDCBA}, 1'b0, '0}
	};

	logic [15:0] fov_plan[6];

	initial begin
		fov_plan = '{16'd0, 16'hFFFF, 16'h0000, 16'd1, 16'h0000, 16'd10923};
		fov_plan[2] = 16'($urandom);
		fov_plan[4] = 16'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_ray(dir_rows[i].ray, dir_rows[i].typed, dir_rows[i].want);
		in_valid <= 1'b0;
		drain_results();

		// random phases, one field of view each; drop idling in the last one
		for (int ph = 0; ph < 6; ph++) begin
			write_fov(fov_plan[ph]);
			if (ph == 5) idle_on = 1'b0;
			for (int n = 0; n < 305; n++) begin
				if (ph == 1 && n == 50) hold_go = 1'b1;
				send_ray(random_ray(fov_model), 1'b0, '0);
			end
			in_valid <= 1'b0;
			drain_results();
		end

		if (fail_count == 0 && pending_sides.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
